// ===== sv/ccurng_pkg.sv =====
// Types and constants shared by the combined congruential uniform generator.
// No dependencies; every other file of the block imports this package.
package ccurng_pkg;

  localparam int unsigned NUM_GEN = 3;
  localparam int unsigned GEN_W   = 15;
  localparam int unsigned FRAC_W  = 32;
  localparam int unsigned SEED_W  = 32;

  localparam int unsigned MOD_A = 30269;
  localparam int unsigned MOD_B = 30307;
  localparam int unsigned MOD_C = 30323;

  // mul * state stays below 2^23; the quotient by the modulus stays below 2^8
  localparam int unsigned PROD_W    = 23;
  localparam int unsigned QUOT_W    = 8;
  localparam int unsigned DIV_SHIFT = 38;
  localparam int unsigned DIV_RCP_W = 24;
  localparam int unsigned DIV_FULL_W = PROD_W + DIV_RCP_W;

  // term = floor(v * 2^32 / m) via ceil(2^62 / m), split in two 24-bit halves
  localparam int unsigned FRAC_SHIFT = 30;
  localparam int unsigned FRAC_RCP_W = 48;
  localparam int unsigned HALF_W     = FRAC_RCP_W / 2;
  localparam int unsigned PART_W     = GEN_W + HALF_W;

  // seed reload: gen_c = SEED_MUL * (seed mod SEED_MOD) + SEED_OFS
  localparam int unsigned SEED_MOD = 178;
  localparam int unsigned SEED_MUL = 170;
  localparam int unsigned SEED_OFS = 137;
  localparam int unsigned REM_W    = 8;

  // seed mod SEED_MOD: fold the bytes by 256^k mod SEED_MOD (sum stays below 2^15),
  // then divide the fold by SEED_MOD through the reciprocal ceil(2^23 / SEED_MOD)
  localparam int unsigned SEED_FOLD_W    = 15;
  localparam int unsigned SEED_FOLD_1    = 256 % SEED_MOD;
  localparam int unsigned SEED_FOLD_2    = 65536 % SEED_MOD;
  localparam int unsigned SEED_FOLD_3    = 16777216 % SEED_MOD;
  localparam int unsigned SEED_RCP_SHIFT = 23;
  localparam int unsigned SEED_RCP_W     = 16;
  localparam int unsigned SEED_PROD_W    = SEED_FOLD_W + SEED_RCP_W;
  localparam int unsigned SEED_RCP       =
    ((32'd1 << SEED_RCP_SHIFT) + SEED_MOD - 32'd1) / SEED_MOD;

  localparam logic [GEN_W-1:0] RESET_A = GEN_W'(11);
  localparam logic [GEN_W-1:0] RESET_B = GEN_W'(23);
  localparam logic [GEN_W-1:0] RESET_C = GEN_W'(SEED_OFS);

  localparam logic [GEN_W-1:0] MODULUS [NUM_GEN] = '{
    GEN_W'(MOD_A), GEN_W'(MOD_B), GEN_W'(MOD_C)
  };

  localparam logic [GEN_W-1:0] MULT [NUM_GEN] = '{
    GEN_W'(171), GEN_W'(172), GEN_W'(170)
  };

  localparam logic [DIV_RCP_W-1:0] DIV_RCP [NUM_GEN] = '{
    DIV_RCP_W'(((64'd1 << DIV_SHIFT) + 64'(MOD_A) - 64'd1) / 64'(MOD_A)),
    DIV_RCP_W'(((64'd1 << DIV_SHIFT) + 64'(MOD_B) - 64'd1) / 64'(MOD_B)),
    DIV_RCP_W'(((64'd1 << DIV_SHIFT) + 64'(MOD_C) - 64'd1) / 64'(MOD_C))
  };

  localparam logic [FRAC_RCP_W-1:0] FRAC_RCP [NUM_GEN] = '{
    FRAC_RCP_W'(((64'd1 << (FRAC_W + FRAC_SHIFT)) + 64'(MOD_A) - 64'd1) / 64'(MOD_A)),
    FRAC_RCP_W'(((64'd1 << (FRAC_W + FRAC_SHIFT)) + 64'(MOD_B) - 64'd1) / 64'(MOD_B)),
    FRAC_RCP_W'(((64'd1 << (FRAC_W + FRAC_SHIFT)) + 64'(MOD_C) - 64'd1) / 64'(MOD_C))
  };

  typedef logic [NUM_GEN-1:0][GEN_W-1:0] gen_vec_t;

  typedef struct packed {
    logic has_room;
    logic has_data;
  } queue_status_t;

endpackage

// ===== sv/ccurng_front.sv =====
// Front end: takes draw beats and seed writes, steps the three generators.
// Depends on ccurng_pkg; pushes each new generator triple into ccurng_queue.
module ccurng_front
  import ccurng_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic                draw,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [SEED_W-1:0]   cfg_data,
  input  queue_status_t       q_stat,
  output logic                push_valid,
  output gen_vec_t            push_data
);

  typedef enum logic [2:0] {
    F_IDLE,
    F_DIV,
    F_WB,
    F_SEED,
    F_REM,
    F_LOAD
  } front_state_t;

  front_state_t                 state;
  gen_vec_t                     gen;
  logic [NUM_GEN-1:0][PROD_W-1:0] prod;
  logic [NUM_GEN-1:0][QUOT_W-1:0] quot;
  logic [SEED_FOLD_W-1:0]       seed_fold;
  logic [QUOT_W-1:0]            seed_quot;
  logic [REM_W-1:0]             rem;

  logic                         in_fire;
  logic                         cfg_fire;
  logic [SEED_FOLD_W-1:0]       fold_next;
  logic [SEED_PROD_W-1:0]       seed_prod;
  gen_vec_t                     gen_next;
  logic [NUM_GEN-1:0][DIV_FULL_W-1:0] div_full;
  logic [GEN_W-1:0]             load_val;

  assign cfg_ready  = (state == F_IDLE);
  assign s_tready   = (state == F_IDLE) && q_stat.has_room && !cfg_valid;
  assign in_fire    = s_tvalid && s_tready;
  assign cfg_fire   = cfg_valid && cfg_ready;
  assign push_valid = (state == F_WB);
  assign push_data  = gen_next;

  always_comb begin
    for (int i = 0; i < NUM_GEN; i++) begin
      div_full[i] = DIV_FULL_W'(prod[i]) * DIV_FULL_W'(DIV_RCP[i]);
      gen_next[i] = GEN_W'(prod[i] - PROD_W'(quot[i]) * PROD_W'(MODULUS[i]));
    end
  end

  // fold the seed bytes into a small value with the same remainder
  always_comb begin
    fold_next = SEED_FOLD_W'(cfg_data[7:0])
              + SEED_FOLD_W'(cfg_data[15:8])  * SEED_FOLD_W'(SEED_FOLD_1)
              + SEED_FOLD_W'(cfg_data[23:16]) * SEED_FOLD_W'(SEED_FOLD_2)
              + SEED_FOLD_W'(cfg_data[31:24]) * SEED_FOLD_W'(SEED_FOLD_3);
    seed_prod = SEED_PROD_W'(seed_fold) * SEED_PROD_W'(SEED_RCP);
    load_val  = GEN_W'(GEN_W'(SEED_MUL) * GEN_W'(rem) + GEN_W'(SEED_OFS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      gen   <= {RESET_C, RESET_B, RESET_A};
      rem   <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (cfg_fire) begin
            seed_fold <= fold_next;
            state     <= F_SEED;
          end else if (in_fire && draw) begin
            for (int i = 0; i < NUM_GEN; i++) begin
              prod[i] <= PROD_W'(MULT[i]) * PROD_W'(gen[i]);
            end
            state <= F_DIV;
          end
        end
        F_DIV: begin
          for (int i = 0; i < NUM_GEN; i++) begin
            quot[i] <= div_full[i][DIV_SHIFT +: QUOT_W];
          end
          state <= F_WB;
        end
        F_WB: begin
          gen   <= gen_next;
          state <= F_IDLE;
        end
        F_SEED: begin
          seed_quot <= seed_prod[SEED_RCP_SHIFT +: QUOT_W];
          state     <= F_REM;
        end
        F_REM: begin
          rem   <= REM_W'(seed_fold - SEED_FOLD_W'(seed_quot) * SEED_FOLD_W'(SEED_MOD));
          state <= F_LOAD;
        end
        F_LOAD: begin
          gen[2] <= load_val;
          state  <= F_IDLE;
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/ccurng_queue.sv =====
// Short queue of generator triples between the front end and the back end.
// Depends on ccurng_pkg for the entry type and status struct.
module ccurng_queue
  import ccurng_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  input  gen_vec_t      push_data,
  input  logic          pop,
  output gen_vec_t      pop_data,
  output queue_status_t q_stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  gen_vec_t          entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign q_stat.has_room = (count != CNT_W'(DEPTH));
  assign q_stat.has_data = (count != '0);
  assign do_push  = push_valid && q_stat.has_room;
  assign do_pop   = pop && q_stat.has_data;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/ccurng_back.sv =====
// Back end: turns a generator triple into a 0.32 fraction and drives the result beat.
// Depends on ccurng_pkg; pops triples from ccurng_queue.
module ccurng_back
  import ccurng_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  queue_status_t     q_stat,
  input  gen_vec_t          pop_data,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [FRAC_W-1:0] m_tdata
);

  localparam int unsigned FULL_W = 64;

  logic                              adv;
  logic                              s1_valid;
  logic                              s2_valid;
  logic [NUM_GEN-1:0][PART_W-1:0]    part_lo;
  logic [NUM_GEN-1:0][PART_W-1:0]    part_hi;
  logic [NUM_GEN-1:0][FRAC_W-1:0]    term;
  logic [NUM_GEN-1:0][FULL_W-1:0]    full;
  logic [FRAC_W-1:0]                 sum;

  // the whole pipe holds while the output beat waits
  assign adv = !m_tvalid || m_tready;
  assign pop = adv && q_stat.has_data;

  always_comb begin
    for (int i = 0; i < NUM_GEN; i++) begin
      full[i] = (FULL_W'(part_hi[i]) << HALF_W) + FULL_W'(part_lo[i]);
    end
    sum = term[0] + term[1] + term[2];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NUM_GEN; i++) begin
        part_lo[i] <= PART_W'(pop_data[i]) * PART_W'(FRAC_RCP[i][HALF_W-1:0]);
        part_hi[i] <= PART_W'(pop_data[i]) * PART_W'(FRAC_RCP[i][FRAC_RCP_W-1:HALF_W]);
        term[i]    <= full[i][FRAC_SHIFT +: FRAC_W];
      end
      m_tdata <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      s1_valid <= q_stat.has_data;
      s2_valid <= s1_valid;
      m_tvalid <= s2_valid;
    end
  end

endmodule

// ===== sv/combined_congruential_uniform_rng_unit.sv =====
// Top level of the combined congruential uniform generator: front end, queue, back end.
// Depends on ccurng_pkg, ccurng_front, ccurng_queue and ccurng_back.
//
//   channel  | dir | handshake            | payload
//   ---------+-----+----------------------+-------------------------------------
//   s_       | in  | s_tvalid / s_tready  | s_tdata[0] draw, [7:1] zero
//   m_       | out | m_tvalid / m_tready  | m_tdata[31:0] uniform_fraction
//   cfg_     | in  | cfg_valid/cfg_ready  | cfg_data[31:0] seed
//
// A draw beat occupies the front end while it steps in turn: multiply by the multipliers,
// quotient by reciprocal multiply, then reduce and write back the state.
// The back end is a 3-stage pipeline: a triple from the queue passes the partial
// products, terms and sum registers. A beat with draw clear is taken and dropped.
// A seed write folds the seed bytes, then takes quotient, remainder and reload;
// input is held off until the reload is done.
// Reset is synchronous; a stalled output fills the queue, then holds s_tready low.
module combined_congruential_uniform_rng_unit
  import ccurng_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [0] draw, [7:1] zero fill
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [FRAC_W-1:0] m_tdata,   // [31:0] uniform_fraction
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SEED_W-1:0] cfg_data
);

  queue_status_t q_stat;
  logic          push_valid;
  gen_vec_t      push_data;
  logic          pop;
  gen_vec_t      pop_data;

  ccurng_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .draw       (s_tdata[0]),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .q_stat     (q_stat),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  ccurng_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .pop        (pop),
    .pop_data   (pop_data),
    .q_stat     (q_stat)
  );

  ccurng_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_stat   (q_stat),
    .pop_data (pop_data),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

`ifndef SYNTHESIS
  a_no_cfg_with_draw: assert property (@(posedge clk) disable iff (rst)
    !(cfg_valid && cfg_ready && s_tvalid && s_tready))
    else $error("seed write and draw beat taken on the same edge");

  a_busy_after_draw: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tdata[0]) |=> (!s_tready && !cfg_ready))
    else $error("front end ready again right after a draw");

  a_busy_after_seed: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> (!s_tready && !cfg_ready))
    else $error("front end ready again right after a seed write");
`endif

endmodule

// ===== test/ccurng_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the combined congruential uniform generator: watches the draw, seed and
// result channels, predicts each fraction and compares it. Depends on ccurng_pkg.
module ccurng_checker
  import ccurng_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [7:0]        s_tdata,    // [0] draw, [7:1] zero fill
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [FRAC_W-1:0] m_tdata,    // [31:0] uniform_fraction
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [SEED_W-1:0] cfg_data,
  output int                fail_count,
  output int                pending_count
);

  localparam int A_MULT = 171;
  localparam int A_QUOT = 177;
  localparam int A_REM  = 2;
  localparam int A_MOD  = 30269;
  localparam int B_MULT = 172;
  localparam int B_QUOT = 176;
  localparam int B_REM  = 35;
  localparam int B_MOD  = 30307;
  localparam int C_MULT = 170;
  localparam int C_QUOT = 178;
  localparam int C_REM  = 63;
  localparam int C_MOD  = 30323;

  localparam logic [14:0] A_START = 15'd11;
  localparam logic [14:0] B_START = 15'd23;
  localparam logic [14:0] C_START = 15'd137;

  localparam int unsigned SEED_SPAN  = 178;
  localparam int unsigned SEED_SCALE = 170;
  localparam int unsigned SEED_BASE  = 137;

  localparam int PRINT_CAP = 100;

  logic [14:0]       gen_a;
  logic [14:0]       gen_b;
  logic [14:0]       gen_c;
  logic [FRAC_W-1:0] expected_fracs[$];
  int                mismatch_total = 0;

  // v <- mul*(v mod q) - r*(v div q), folded back into [0, m)
  function automatic logic [14:0] schrage_step(logic [14:0] v, int mul, int q, int r, int m);
    int x;
    int t;
    x = int'(v);
    t = mul * (x % q) - r * (x / q);
    if (t < 0) t += m;
    if (t < 0) t = 0;
    if (t >= m) t -= m;
    return 15'(t);
  endfunction

  // truncated v / m as an unsigned 0.32 fraction
  function automatic logic [FRAC_W-1:0] frac_of(logic [14:0] v, int m);
    logic [63:0] num;
    num = {17'd0, v, 32'd0};
    return 32'(num / 64'(m));
  endfunction

  function automatic logic [14:0] reload_from_seed(logic [SEED_W-1:0] seed_word);
    return 15'(SEED_SCALE * (seed_word % SEED_SPAN) + SEED_BASE);
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_total < PRINT_CAP) $display("%0t ns ccurng_checker: %s", $time, what);
    mismatch_total++;
  endtask

  always @(posedge clk) begin : track
    logic [FRAC_W-1:0] sum;
    logic [FRAC_W-1:0] want;
    if (rst) begin
      gen_a = A_START;
      gen_b = B_START;
      gen_c = C_START;
      expected_fracs.delete();
    end else begin
      if (cfg_valid && cfg_ready) gen_c = reload_from_seed(cfg_data);
      // a beat with draw clear advances nothing
      if (s_tvalid && s_tready && s_tdata[0]) begin
        gen_a = schrage_step(gen_a, A_MULT, A_QUOT, A_REM, A_MOD);
        gen_b = schrage_step(gen_b, B_MULT, B_QUOT, B_REM, B_MOD);
        gen_c = schrage_step(gen_c, C_MULT, C_QUOT, C_REM, C_MOD);
        sum = frac_of(gen_a, A_MOD);
        sum = sum + frac_of(gen_b, B_MOD);
        sum = sum + frac_of(gen_c, C_MOD);
        expected_fracs.push_back(sum);
      end
      if (m_tvalid && m_tready) begin
        if (expected_fracs.size() == 0) begin
          report_mismatch($sformatf("result beat %08h with no draw outstanding", m_tdata));
        end else begin
          want = expected_fracs.pop_front();
          if (m_tdata !== want)
            report_mismatch($sformatf("uniform_fraction %08h, predicted %08h", m_tdata, want));
        end
      end
    end
    pending_count <= expected_fracs.size();
    fail_count    <= mismatch_total;
  end

endmodule

// ===== test/combined_congruential_uniform_rng_unit_tb.sv =====
`timescale 1ns / 1ps
// Regression top for the combined congruential uniform generator: clock, reset, draw and
// seed stimulus, output back-pressure, verdict. Depends on the block and ccurng_checker.
module combined_congruential_uniform_rng_unit_tb;
  import ccurng_pkg::*;

  localparam int DRAWS_PER_PHASE = 126;
  localparam int NUM_PHASES      = 8;
  localparam int PRESSURE_PHASE  = 1;
  localparam int LONG_HOLD       = 200;
  localparam int SETTLE_CYCLES   = 16;
  localparam int LIMIT_CYCLES    = 400000;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [7:0]        s_tdata;   // [0] draw, [7:1] zero fill
  logic              m_tvalid;
  logic              m_tready;
  logic [FRAC_W-1:0] m_tdata;   // [31:0] uniform_fraction
  logic              cfg_valid;
  logic              cfg_ready;
  logic [SEED_W-1:0] cfg_data;

  int  fail_count;
  int  pending_count;
  int  cycle_count = 0;
  bit  quiet       = 1'b0;
  bit  hold_req    = 1'b0;

  combined_congruential_uniform_rng_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  ccurng_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("combined_congruential_uniform_rng_unit regression: fail");
    $finish;
  end

  // result side: random stall bursts, one long hold-off, none at the end
  initial begin
    m_tready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        m_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_beat(input logic draw_bit);
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, draw_bit};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic idle_source(input int cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // wait for every predicted fraction, then let the pipe settle
  task automatic drain_draws();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [SEED_W-1:0] seed_word);
    drain_draws();
    cfg_valid <= 1'b1;
    cfg_data  <= seed_word;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int   draws;
    logic draw_bit;
    bit   gaps_on;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = 8'd0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset state: back-to-back draws, dropped beats, spaced draws
    repeat (6) send_beat(1'b1);
    send_beat(1'b0);
    send_beat(1'b1);
    idle_source(3);
    send_beat(1'b1);
    send_beat(1'b0);
    send_beat(1'b0);
    send_beat(1'b1);
    // seed extremes: remainder zero, all ones, largest remainder, wrap to zero
    write_seed(32'd0);
    repeat (3) send_beat(1'b1);
    write_seed(32'hFFFF_FFFF);
    repeat (3) send_beat(1'b1);
    write_seed(32'd177);
    repeat (3) send_beat(1'b1);
    write_seed(32'd178);
    repeat (2) send_beat(1'b1);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      write_seed($urandom);
      quiet   = (phase == NUM_PHASES - 1);
      gaps_on = !quiet && phase != PRESSURE_PHASE && $urandom_range(0, 3) != 0;
      // keep offering draws while the result side holds off
      if (phase == PRESSURE_PHASE) hold_req = 1'b1;
      draws = 0;
      while (draws < DRAWS_PER_PHASE) begin
        if (gaps_on && $urandom_range(0, 3) == 0) idle_source($urandom_range(1, 8));
        draw_bit = ($urandom_range(0, 9) != 0);
        send_beat(draw_bit);
        if (draw_bit) draws++;
      end
    end

    drain_draws();
    if (fail_count == 0) begin
      $display("combined_congruential_uniform_rng_unit regression: pass");
    end else begin
      $display("combined_congruential_uniform_rng_unit regression: fail");
    end
    $finish;
  end

endmodule
